[rtl/core/mmpq_pkg.sv]
// shared constants for the min/max priority queue
package mmpq_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 2;
  localparam int ST_W         = 2;
  localparam int OCC_W        = 4;
  localparam int OUT_DATA_W   = 40;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_RMIN   = 2'd1;
  localparam logic [OP_W-1:0] OP_RMAX   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

[rtl/core/mmpq_store.sv]
// entry memory: one write port, one registered read port
module mmpq_store #(
  parameter int DEPTH = mmpq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  mmpq_pkg::val_t wdata,
  input  logic [AW-1:0]  raddr,
  output mmpq_pkg::val_t rdata
);

  mmpq_pkg::val_t mem [DEPTH];
  mmpq_pkg::val_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/min_max_priority_queue.sv]
// double-ended priority queue over an unsorted entry memory
// insert, unused opcode or error result: goes straight to S_FIN, which registers the result once the output is free
// removal: S_SCAN reads all count entries past one comparator, then S_SHIFT moves the entries
// above the removed one down through the memory's one read port and one write port, then S_FIN
// one request at a time, next one taken the cycle after its result is registered
// reset (synchronous, active low) empties the queue; entry memory is not cleared
module min_max_priority_queue #(
  parameter int CAPACITY = mmpq_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mmpq_pkg::VAL_W-1:0]       in_tdata,   // value
  input  logic [mmpq_pkg::OP_W-1:0]        in_tuser,   // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mmpq_pkg::OUT_DATA_W-1:0]  out_tdata,  // removed_value, occupancy, zero pad
  output logic [mmpq_pkg::ST_W-1:0]        out_tuser   // status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [mmpq_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [mmpq_pkg::ST_W-1:0]   st_r, st_nxt;
  mmpq_pkg::val_t              best_r, best_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               rx_r, rx_nxt;
  logic [CW-1:0]               sh_r, sh_nxt;
  logic                        pv_r, pv_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [mmpq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [mmpq_pkg::ST_W-1:0]   out_user_r, out_user_nxt;

  logic                        we;
  logic [AW-1:0]               waddr;
  mmpq_pkg::val_t              wdata;
  logic [AW-1:0]               raddr;
  mmpq_pkg::val_t              rd_data;

  logic                        better;
  logic [CW-1:0]               rx_inc;
  logic [CW-1:0]               s_cur;
  logic [CW-1:0]               s_inc;

  mmpq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign rx_inc = rx_r + CW'(1);
  assign s_cur  = pv_r ? (sh_r + CW'(1)) : sh_r;
  assign s_inc  = s_cur + CW'(1);

  always_comb begin
    if (rx_r == '0) begin
      better = 1'b1;
    end else if (op_r == mmpq_pkg::OP_RMAX) begin
      better = best_r < rd_data;
    end else begin
      better = rd_data < best_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    st_nxt         = st_r;
    best_nxt       = best_r;
    pos_nxt        = pos_r;
    rx_nxt         = rx_r;
    sh_nxt         = sh_r;
    pv_nxt         = pv_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    raddr          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          best_nxt = '0;
          st_nxt   = mmpq_pkg::ST_OK;
          case (in_tuser)
            mmpq_pkg::OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                st_nxt = mmpq_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = in_tdata;
                count_nxt = count_r + CW'(1);
              end
              state_nxt = S_FIN;
            end
            mmpq_pkg::OP_RMIN, mmpq_pkg::OP_RMAX: begin
              if (count_r == '0) begin
                st_nxt    = mmpq_pkg::ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                raddr     = '0;
                rx_nxt    = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (better) begin
          best_nxt = rd_data;
          pos_nxt  = rx_r;
        end
        raddr = rx_inc[AW-1:0];
        if (rx_inc == count_r) begin
          sh_nxt    = better ? rx_r : pos_r;
          pv_nxt    = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          rx_nxt = rx_inc;
        end
      end
      S_SHIFT: begin
        if (pv_r) begin
          we    = 1'b1;
          waddr = sh_r[AW-1:0];
          wdata = rd_data;
        end
        sh_nxt = s_cur;
        if (s_inc < count_r) begin
          raddr  = s_inc[AW-1:0];
          pv_nxt = 1'b1;
        end else begin
          pv_nxt    = 1'b0;
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {4'b0000, mmpq_pkg::OCC_W'(count_r), best_r};
          out_user_nxt   = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
      pv_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      pv_r         <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    st_r       <= st_nxt;
    best_r     <= best_nxt;
    pos_r      <= pos_nxt;
    rx_r       <= rx_nxt;
    sh_r       <= sh_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule
